[design/qip_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the quadraphonic intensity panner.
// Depends on nothing; used by every module of the block.
package qip_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int PERIOD_BITS = 16;
    localparam int FACTOR_BITS = 16;

    localparam logic [1:0] IDX_LAST = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [15:0]                   amplitude;
        logic signed [15:0]            pos_x;
        logic signed [15:0]            pos_y;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_front_left;
        logic signed [SAMPLE_BITS-1:0] out_front_right;
        logic signed [SAMPLE_BITS-1:0] out_back_left;
        logic signed [SAMPLE_BITS-1:0] out_back_right;
    } t_out_word;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ,
        OP_FINIT,
        OP_FMUL,
        OP_FCMP,
        OP_FSTORE,
        OP_GAIN,
        OP_AG,
        OP_SG,
        OP_OUT,
        OP_EMIT
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SQ,
        S_FINIT,
        S_FMUL,
        S_FCMP,
        S_GAIN,
        S_AG,
        S_SG,
        S_OUT,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic recompute;
        logic search_done;
        logic out_busy;
    } t_dp_status;

endpackage

[design/quad_intensity_panner.sv]
`timescale 1ns / 1ps
// Top level of the quadraphonic intensity panner.
// Depends on qip_pkg, qip_ctrl and qip_dp.
//
// One input word is taken at a time. A word that does not move the held
// position has its result word formed by four passes through the
// amplitude-gain and sample multipliers. A word that latches a new position
// first recomputes the four gains by a bisection search per pan factor,
// over fifteen or sixteen steps. The next word can be taken in the cycle
// after the result has moved to the output register, which holds it until
// the sink takes it.
module quad_intensity_panner (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [qip_pkg::PERIOD_BITS-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  qip_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output qip_pkg::t_out_word                o_out_word
);

    qip_pkg::t_dp_cmd    w_cmd;
    qip_pkg::t_dp_status w_status;

    qip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    qip_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .o_out_valid (o_out_valid),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule

[design/qip_ctrl.sv]
`timescale 1ns / 1ps
// Sequencing state machine of the quadraphonic intensity panner.
// Depends on qip_pkg; drives the datapath through command and status structs.
module qip_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  qip_pkg::t_dp_status i_status,
    output qip_pkg::t_dp_cmd    o_cmd
);

    qip_pkg::t_state r_state, n_state;
    logic [1:0]      r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qip_pkg::S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            qip_pkg::S_IDLE: begin
                if (i_in_valid) n_state = qip_pkg::S_CHECK;
            end
            qip_pkg::S_CHECK: begin
                n_idx   = '0;
                n_state = i_status.recompute ? qip_pkg::S_SQ : qip_pkg::S_AG;
            end
            qip_pkg::S_SQ:    n_state = qip_pkg::S_FINIT;
            qip_pkg::S_FINIT: n_state = qip_pkg::S_FMUL;
            qip_pkg::S_FMUL: begin
                if (i_status.search_done) begin
                    if (r_idx == qip_pkg::IDX_LAST) begin
                        n_idx   = '0;
                        n_state = qip_pkg::S_GAIN;
                    end else begin
                        n_idx   = r_idx + 2'd1;
                        n_state = qip_pkg::S_FINIT;
                    end
                end else begin
                    n_state = qip_pkg::S_FCMP;
                end
            end
            qip_pkg::S_FCMP: n_state = qip_pkg::S_FMUL;
            qip_pkg::S_GAIN: begin
                if (r_idx == qip_pkg::IDX_LAST) begin
                    n_idx   = '0;
                    n_state = qip_pkg::S_AG;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            qip_pkg::S_AG: n_state = qip_pkg::S_SG;
            qip_pkg::S_SG: n_state = qip_pkg::S_OUT;
            qip_pkg::S_OUT: begin
                if (r_idx == qip_pkg::IDX_LAST) begin
                    n_state = qip_pkg::S_EMIT;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = qip_pkg::S_AG;
                end
            end
            qip_pkg::S_EMIT: begin
                if (!i_status.out_busy) n_state = qip_pkg::S_IDLE;
            end
            default: n_state = qip_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = qip_pkg::OP_NONE;
        o_cmd.idx  = r_idx;
        unique case (r_state)
            qip_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = qip_pkg::OP_LOAD;
            end
            qip_pkg::S_CHECK: o_cmd.op = qip_pkg::OP_NONE;
            qip_pkg::S_SQ:    o_cmd.op = qip_pkg::OP_SQ;
            qip_pkg::S_FINIT: o_cmd.op = qip_pkg::OP_FINIT;
            qip_pkg::S_FMUL: begin
                o_cmd.op = i_status.search_done ? qip_pkg::OP_FSTORE : qip_pkg::OP_FMUL;
            end
            qip_pkg::S_FCMP: o_cmd.op = qip_pkg::OP_FCMP;
            qip_pkg::S_GAIN: o_cmd.op = qip_pkg::OP_GAIN;
            qip_pkg::S_AG:   o_cmd.op = qip_pkg::OP_AG;
            qip_pkg::S_SG:   o_cmd.op = qip_pkg::OP_SG;
            qip_pkg::S_OUT:  o_cmd.op = qip_pkg::OP_OUT;
            qip_pkg::S_EMIT: begin
                if (!i_status.out_busy) o_cmd.op = qip_pkg::OP_EMIT;
            end
            default: o_cmd.op = qip_pkg::OP_NONE;
        endcase
    end

endmodule

[design/qip_dp.sv]
`timescale 1ns / 1ps
// Datapath of the quadraphonic intensity panner: latch logic, gain search,
// speaker products and the output register. Depends on qip_pkg.
module qip_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [qip_pkg::PERIOD_BITS-1:0]       i_cfg_data,
    input  qip_pkg::t_in_word                     i_in_word,
    input  logic                                  i_out_ready,
    output qip_pkg::t_out_word                    o_out_word,
    output logic                                  o_out_valid,
    input  qip_pkg::t_dp_cmd                      i_cmd,
    output qip_pkg::t_dp_status                   o_status
);

    localparam int SB = qip_pkg::SAMPLE_BITS;
    localparam int FB = qip_pkg::FACTOR_BITS;
    localparam int PW = SB + 33;
    localparam int RW = PW - 27;

    localparam logic signed [RW-1:0] SAT_MAX = {{(RW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_MIN = {{(RW-SB+1){1'b1}}, {(SB-1){1'b0}}};
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(64'd1 << 26);
    localparam logic [29:0] SQ_BASE = 30'd1 << 28;
    localparam logic [FB-1:0] FAC_ONE = FB'(32768);

    function automatic logic signed [15:0] clamp_pos(input logic signed [15:0] v);
        logic signed [15:0] r;
        r = v;
        if (v < -16'sd16384) r = -16'sd16384;
        if (v > 16'sd16384) r = 16'sd16384;
        return r;
    endfunction

    logic [qip_pkg::PERIOD_BITS-1:0] r_period, r_countdown;
    logic [15:0]                     r_amp;
    logic signed [15:0]              r_x, r_y;
    logic                            r_known, r_recompute, r_out_valid;
    logic [FB-1:0]                   r_lo, r_hi;

    logic signed [SB-1:0] r_sample;
    logic [29:0]          r_sx, r_sy, r_s;
    logic [61:0]          r_rhs;
    logic [FB-1:0]        r_mid;
    logic [31:0]          r_m;
    logic [FB-1:0]        r_fac_l, r_fac_r, r_fac_f, r_fac_b;
    logic [FB-1:0]        r_gain [4];
    logic [31:0]          r_q;
    logic signed [PW-1:0] r_p;
    logic signed [SB-1:0] r_res [4];
    qip_pkg::t_out_word   r_out_word;

    logic signed [15:0] w_nx, w_ny;
    logic               w_latch, w_change;
    logic signed [31:0] w_xx, w_yy;
    logic signed [16:0] w_a_full;
    logic [FB-1:0]      w_a;
    logic [31:0]        w_aa;
    logic [16:0]        w_mid_sum;
    logic [FB-1:0]      w_mid, w_t;
    logic [61:0]        w_prod;
    logic [FB-1:0]      w_fa, w_fb;
    logic [31:0]        w_gp;
    logic signed [PW-1:0] w_prnd;
    logic signed [RW-1:0] w_round;
    logic signed [SB-1:0] w_sat;

    assign w_nx     = clamp_pos(i_in_word.pos_x);
    assign w_ny     = clamp_pos(i_in_word.pos_y);
    assign w_latch  = (r_countdown <= 16'd1);
    assign w_change = !r_known || (w_nx != r_x) || (w_ny != r_y);
    assign w_xx     = r_x * r_x;
    assign w_yy     = r_y * r_y;

    always_comb begin
        case (i_cmd.idx)
            2'd0:    w_a_full = 17'sd16384 - {r_x[15], r_x};
            2'd1:    w_a_full = 17'sd16384 + {r_x[15], r_x};
            2'd2:    w_a_full = 17'sd16384 + {r_y[15], r_y};
            default: w_a_full = 17'sd16384 - {r_y[15], r_y};
        endcase
    end
    assign w_a  = w_a_full[FB-1:0];
    assign w_aa = w_a * w_a;

    assign w_mid_sum = (17'(r_lo) + 17'(r_hi) + 17'd1) >> 1;
    assign w_mid     = w_mid_sum[FB-1:0];
    assign w_t       = FB'({w_mid, 1'b0} - 17'd1);
    assign w_prod    = 62'(r_m * r_s);

    assign w_fa = i_cmd.idx[0] ? r_fac_r : r_fac_l;
    assign w_fb = i_cmd.idx[1] ? r_fac_b : r_fac_f;
    assign w_gp = w_fa * w_fb + 32'd16384;

    assign w_prnd  = r_p + ROUND_HALF;
    assign w_round = RW'(w_prnd >>> 27);

    always_comb begin
        if (w_round > SAT_MAX) begin
            w_sat = SAT_MAX[SB-1:0];
        end else if (w_round < SAT_MIN) begin
            w_sat = SAT_MIN[SB-1:0];
        end else begin
            w_sat = w_round[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= 16'd1;
            r_countdown <= '0;
            r_amp       <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_known     <= 1'b0;
            r_recompute <= 1'b0;
            r_out_valid <= 1'b0;
            r_lo        <= '0;
            r_hi        <= '0;
        end else begin
            if (i_cfg_we) r_period <= i_cfg_data;
            if (i_cmd.op == qip_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                qip_pkg::OP_LOAD: begin
                    if (w_latch) begin
                        r_amp       <= i_in_word.amplitude;
                        r_countdown <= (r_period == '0) ? 16'd1 : r_period;
                        r_recompute <= w_change;
                        if (w_change) begin
                            r_x     <= w_nx;
                            r_y     <= w_ny;
                            r_known <= 1'b1;
                        end
                    end else begin
                        r_countdown <= r_countdown - 16'd1;
                        r_recompute <= 1'b0;
                    end
                end
                qip_pkg::OP_FINIT: begin
                    r_lo <= '0;
                    r_hi <= FAC_ONE;
                end
                qip_pkg::OP_FCMP: begin
                    if (w_prod <= r_rhs) begin
                        r_lo <= r_mid;
                    end else begin
                        r_hi <= r_mid - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            qip_pkg::OP_LOAD: r_sample <= i_in_word.sample;
            qip_pkg::OP_SQ: begin
                r_sx <= SQ_BASE + w_xx[29:0];
                r_sy <= SQ_BASE + w_yy[29:0];
            end
            qip_pkg::OP_FINIT: begin
                r_s   <= i_cmd.idx[1] ? r_sy : r_sx;
                r_rhs <= {w_aa[30:0], 31'b0};
            end
            qip_pkg::OP_FMUL: begin
                r_mid <= w_mid;
                r_m   <= w_t * w_t;
            end
            qip_pkg::OP_FSTORE: begin
                case (i_cmd.idx)
                    2'd0:    r_fac_l <= r_lo;
                    2'd1:    r_fac_r <= r_lo;
                    2'd2:    r_fac_f <= r_lo;
                    default: r_fac_b <= r_lo;
                endcase
            end
            qip_pkg::OP_GAIN: r_gain[i_cmd.idx] <= w_gp[30:15];
            qip_pkg::OP_AG:   r_q <= r_amp * r_gain[i_cmd.idx];
            qip_pkg::OP_SG:   r_p <= PW'(r_sample * $signed({1'b0, r_q}));
            qip_pkg::OP_OUT:  r_res[i_cmd.idx] <= w_sat;
            qip_pkg::OP_EMIT: begin
                r_out_word.out_front_left  <= r_res[0];
                r_out_word.out_front_right <= r_res[1];
                r_out_word.out_back_left   <= r_res[2];
                r_out_word.out_back_right  <= r_res[3];
            end
            default: ;
        endcase
    end

    assign o_out_word            = r_out_word;
    assign o_out_valid           = r_out_valid;
    assign o_status.recompute    = r_recompute;
    assign o_status.search_done  = (r_lo == r_hi);
    assign o_status.out_busy     = r_out_valid && !i_out_ready;

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == qip_pkg::OP_EMIT) |-> (!r_out_valid || i_out_ready))
        else $error("Result word emitted over an untaken one.");
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo <= r_hi)
        else $error("Gain search bounds crossed.");
    a_countdown_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == qip_pkg::OP_LOAD) |=> (r_countdown != '0))
        else $error("Latch countdown left at zero.");
    a_known_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == qip_pkg::OP_LOAD) |=> r_known)
        else $error("Position not held after a word was taken.");
`endif

endmodule

[bench/tb_quad_intensity_panner.sv]
`timescale 1ns / 1ps
// Self-checking testbench for quad_intensity_panner: random and directed words
// are checked against a predictor of the pan law kept in a scoreboard class.
// Depends on qip_pkg and quad_intensity_panner.
module tb_quad_intensity_panner;

    localparam int SB = qip_pkg::SAMPLE_BITS;

    class panner_scoreboard;
        qip_pkg::t_out_word speaker_q[$];
        int         fails;
        logic [15:0] period;
        logic [15:0] countdown;
        logic [15:0] amp;
        int         hx;
        int         hy;
        bit         known;
        longint     gain[4];

        function new();
            fails = 0;
            period = 16'd1;
            countdown = 0;
            amp = 0;
            hx = 0;
            hy = 0;
            known = 0;
            foreach (gain[k]) gain[k] = 0;
        endfunction

        function int clamp_q(logic signed [15:0] v);
            int r;
            r = v;
            if (r < -16384) r = -16384;
            if (r > 16384) r = 16384;
            return r;
        endfunction

        function longint unsigned factor(longint unsigned a, longint unsigned s);
            longint unsigned lo, hi, mid, t, rhs;
            lo = 0;
            hi = 32768;
            rhs = (a * a) << 31;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                t = 2 * mid - 1;
                if (t * t * s <= rhs) lo = mid;
                else hi = mid - 1;
            end
            return lo;
        endfunction

        function void recompute();
            longint unsigned sx, sy, l, r, f, b;
            sx = (64'd1 << 28) + longint'(hx * hx);
            sy = (64'd1 << 28) + longint'(hy * hy);
            l = factor(16384 - hx, sx);
            r = factor(16384 + hx, sx);
            f = factor(16384 + hy, sy);
            b = factor(16384 - hy, sy);
            gain[0] = (l * f + 16384) >> 15;
            gain[1] = (r * f + 16384) >> 15;
            gain[2] = (l * b + 16384) >> 15;
            gain[3] = (r * b + 16384) >> 15;
        endfunction

        function logic signed [SB-1:0] speaker_out(longint s, int k);
            longint p;
            p = s * longint'(amp) * gain[k];
            p = (p + (64'sd1 <<< 26)) >>> 27;
            if (p > 64'sd8388607) p = 64'sd8388607;
            if (p < -64'sd8388608) p = -64'sd8388608;
            return p[SB-1:0];
        endfunction

        function void note_input(qip_pkg::t_in_word w);
            int nx, ny;
            longint s;
            qip_pkg::t_out_word o;
            if (countdown <= 16'd1) begin
                nx = clamp_q(w.pos_x);
                ny = clamp_q(w.pos_y);
                amp = w.amplitude;
                if (!known || nx != hx || ny != hy) begin
                    hx = nx;
                    hy = ny;
                    known = 1;
                    recompute();
                end
                countdown = (period == 0) ? 16'd1 : period;
            end else begin
                countdown = countdown - 16'd1;
            end
            s = longint'(w.sample);
            o.out_front_left  = speaker_out(s, 0);
            o.out_front_right = speaker_out(s, 1);
            o.out_back_left   = speaker_out(s, 2);
            o.out_back_right  = speaker_out(s, 3);
            speaker_q.push_back(o);
        endfunction

        task report(string what, logic [SB-1:0] got, logic [SB-1:0] want);
            $display("mismatch %s: got %0d expected %0d", what,
                     $signed(got), $signed(want));
            fails++;
        endtask

        task check(qip_pkg::t_out_word w);
            qip_pkg::t_out_word e;
            if (speaker_q.size() == 0) begin
                $display("unexpected output word");
                fails++;
            end else begin
                e = speaker_q.pop_front();
                if (w.out_front_left !== e.out_front_left)
                    report("front left", w.out_front_left, e.out_front_left);
                if (w.out_front_right !== e.out_front_right)
                    report("front right", w.out_front_right, e.out_front_right);
                if (w.out_back_left !== e.out_back_left)
                    report("back left", w.out_back_left, e.out_back_left);
                if (w.out_back_right !== e.out_back_right)
                    report("back right", w.out_back_right, e.out_back_right);
            end
        endtask
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [qip_pkg::PERIOD_BITS-1:0] i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    qip_pkg::t_in_word               i_in_word = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    qip_pkg::t_out_word              o_out_word;

    panner_scoreboard sb = new();
    bit   hold_request = 0;
    int   burst_left = 0;
    logic signed [15:0] pos_pool[8];

    quad_intensity_panner u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check(o_out_word);
    end

    initial begin
        int mode;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_request = 0;
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(5, 40)) begin
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    2: i_out_ready <= $urandom_range(0, 1);
                    default: i_out_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task send_word(qip_pkg::t_in_word w);
        bit go;
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        do begin
            @(negedge i_clk);
            go = o_in_ready;
            @(posedge i_clk);
        end while (!go);
        sb.note_input(w);
        burst_left--;
    endtask

    task drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.speaker_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task write_period(logic [15:0] v);
        i_cfg_data <= v;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.period = v;
    endtask

    function qip_pkg::t_in_word random_word();
        qip_pkg::t_in_word w;
        w.sample    = SB'($urandom);
        w.amplitude = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192));
        if ($urandom_range(0, 3) != 0) begin
            w.pos_x = pos_pool[$urandom_range(0, 7)];
            w.pos_y = pos_pool[$urandom_range(0, 7)];
        end else begin
            w.pos_x = 16'($urandom);
            w.pos_y = 16'($urandom);
        end
        return w;
    endfunction

    task run_random(int count);
        repeat (count) send_word(random_word());
    endtask

    initial begin
        qip_pkg::t_in_word w;
        logic signed [15:0] edge_pos[7];
        edge_pos = '{16'sh8000, 16'sh7fff, -16'sd16384, 16'sd16384, 16'sd0,
                     -16'sd16385, 16'sd16385};
        foreach (pos_pool[k]) pos_pool[k] = 16'($urandom);
        pos_pool[0] = 16'sd0;
        pos_pool[1] = 16'sd16384;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (edge_pos[k]) begin
            w.sample = (k % 2) ? 24'sh7fffff : 24'sh800000;
            w.amplitude = (k % 3 == 0) ? 16'hffff : 16'h1000;
            w.pos_x = edge_pos[k];
            w.pos_y = edge_pos[(k + 3) % 7];
            send_word(w);
            send_word(w);
        end
        w.amplitude = 16'h0000;
        send_word(w);
        w.sample = 24'sd1;
        w.amplitude = 16'h1000;
        send_word(w);
        w.sample = -24'sd1;
        send_word(w);

        drain();
        write_period(16'd0);
        run_random(200);
        hold_request = 1;
        run_random(30);
        drain();
        write_period(16'd3);
        run_random(200);
        drain();
        write_period(16'hffff);
        run_random(100);
        drain();
        write_period(16'd7);
        run_random(200);
        hold_request = 1;
        run_random(20);
        drain();
        write_period(16'd1);
        run_random(230);
        drain();

        if (sb.fails == 0 && sb.speaker_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
